FILE: rtl/core/dapss_pkg.sv
// Shared types, widths and fixed-point constants for the dual angle PID steering unit.
// No dependencies; every module of the block imports this package.
package dapss_pkg;

   localparam int FRAC_BITS = 12;
   localparam int ACC_WIDTH = 32;

   localparam int ERR_W   = 16;
   localparam int GAIN_W  = 16;
   localparam int TICK_W  = 16;
   localparam int OUT_W   = 24;
   localparam int CSR_IDX_W = 3;

   // Wide enough to hold the input plus or minus two pi at any FRAC_BITS in range
   localparam int WRAP_W  = ERR_W + 3;
   localparam int RATE_W  = ERR_W + 1;

   // Product widths: unsigned gain (zero-extended) times signed operand
   localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
   localparam int PROD_I_W = GAIN_W + 1 + ACC_WIDTH;
   localparam int PROD_D_W = GAIN_W + 1 + RATE_W;
   localparam int TERM_P_W = PROD_P_W - FRAC_BITS;
   localparam int TERM_I_W = PROD_I_W - FRAC_BITS;
   localparam int TERM_D_W = PROD_D_W - FRAC_BITS;

   // Headroom for the sum of six terms
   localparam int SUM_W = TERM_I_W + 3;

   localparam longint PI_Q30 = 64'sd3373259426;
   localparam longint PI_L   = (PI_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
   localparam logic signed [WRAP_W-1:0] PI_FX     = WRAP_W'(PI_L);
   localparam logic signed [WRAP_W-1:0] TWO_PI_FX = WRAP_W'(2 * PI_L);

   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   localparam logic [TICK_W-1:0] TICKS_SAT = {TICK_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_KP = 3'd0,
      CSR_TARGET_KI = 3'd1,
      CSR_TARGET_KD = 3'd2,
      CSR_DOCK_KP   = 3'd3,
      CSR_DOCK_KI   = 3'd4,
      CSR_DOCK_KD   = 3'd5,
      CSR_TIMEOUT   = 3'd6
   } csr_index_type;

   localparam logic [GAIN_W-1:0] KP_RESET      = 16'd2048;
   localparam logic [GAIN_W-1:0] KI_RESET      = 16'd410;
   localparam logic [GAIN_W-1:0] KD_RESET      = 16'd205;
   localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd200;

   typedef struct packed {
      logic [GAIN_W-1:0] kp;
      logic [GAIN_W-1:0] ki;
      logic [GAIN_W-1:0] kd;
   } gains_type;

   // One classified tick as it travels from front to back
   typedef struct packed {
      logic signed [ERR_W-1:0] target_error;
      logic signed [ERR_W-1:0] dock_error;
      logic                    timed_out;
   } tick_type;

endpackage

FILE: rtl/core/dual_angle_pid_steering_unit.sv
// Each accepted tick passes the queue entry, then the stage-1, stage-2 and output registers.
// Throughput: one tick per cycle unless rsp_ready stalls the output; each PID loop updates its integral in place.
// While a result waits, the back stages and the two-entry queue take further ticks;
// req_ready drops once the queue holds two. Reset (synchronous): gains and timeout take
// their defaults, loop state clears, and the detection timer starts saturated.
// Depends on dapss_pkg, dapss_front, dapss_queue and dapss_back.
module dual_angle_pid_steering_unit
   import dapss_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [GAIN_W-1:0]       csr_data,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [ERR_W-1:0] req_target_error,
   input  logic signed [ERR_W-1:0] req_dock_error,
   input  logic                    req_target_seen,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [OUT_W-1:0] rsp_steer_command,
   output logic                    rsp_timed_out
);

   gains_type         target_gains_ff;
   gains_type         dock_gains_ff;
   logic [TICK_W-1:0] timeout_ff;

   logic     push_valid, pop_valid, pop_ready;
   tick_type push_tick, pop_tick;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_gains_ff <= '{kp: KP_RESET, ki: KI_RESET, kd: KD_RESET};
         dock_gains_ff   <= '{kp: KP_RESET, ki: KI_RESET, kd: KD_RESET};
         timeout_ff      <= TIMEOUT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TARGET_KP: target_gains_ff.kp <= csr_data;
            CSR_TARGET_KI: target_gains_ff.ki <= csr_data;
            CSR_TARGET_KD: target_gains_ff.kd <= csr_data;
            CSR_DOCK_KP:   dock_gains_ff.kp   <= csr_data;
            CSR_DOCK_KI:   dock_gains_ff.ki   <= csr_data;
            CSR_DOCK_KD:   dock_gains_ff.kd   <= csr_data;
            CSR_TIMEOUT:   timeout_ff         <= csr_data;
            default: ; // drop writes to unknown indexes
         endcase
      end
   end

   dapss_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_target_error (req_target_error),
      .req_dock_error   (req_dock_error),
      .req_target_seen  (req_target_seen),
      .timeout_ticks    (timeout_ff),
      .push_valid       (push_valid),
      .push_tick        (push_tick)
   );

   dapss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_tick  (push_tick),
      .push_ready (req_ready),
      .pop_ready  (pop_ready),
      .pop_valid  (pop_valid),
      .pop_tick   (pop_tick)
   );

   dapss_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_tick          (pop_tick),
      .pop_ready         (pop_ready),
      .target_gains      (target_gains_ff),
      .dock_gains        (dock_gains_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_steer_command (rsp_steer_command),
      .rsp_timed_out     (rsp_timed_out)
   );

endmodule

FILE: rtl/core/dapss_front.sv
// Front end: takes input transfers, wraps both bearing errors and runs the detection timer.
// Depends on dapss_pkg.
module dapss_front
   import dapss_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic signed [ERR_W-1:0] req_target_error,
   input  logic signed [ERR_W-1:0] req_dock_error,
   input  logic                    req_target_seen,
   input  logic [TICK_W-1:0]       timeout_ticks,
   output logic                    push_valid,
   output tick_type                push_tick
);

   logic [TICK_W-1:0] ticks_ff;
   logic [TICK_W-1:0] ticks_in;

   function automatic logic signed [ERR_W-1:0] wrap_angle(input logic signed [ERR_W-1:0] err);
      logic signed [WRAP_W-1:0] e;
      e = WRAP_W'(err);
      if (e > PI_FX) begin
         e = e - TWO_PI_FX;
      end
      if (e < -PI_FX) begin
         e = e + TWO_PI_FX;
      end
      return e[ERR_W-1:0];
   endfunction

   always_comb begin
      if (req_target_seen) begin
         ticks_in = '0;
      end else if (ticks_ff != TICKS_SAT) begin
         ticks_in = ticks_ff + 1'b1;
      end else begin
         ticks_in = ticks_ff;
      end
   end

   assign push_valid             = req_valid && req_ready;
   assign push_tick.target_error = wrap_angle(req_target_error);
   assign push_tick.dock_error   = wrap_angle(req_dock_error);
   assign push_tick.timed_out    = ticks_in > timeout_ticks;

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= TICKS_SAT;
      end else if (push_valid) begin
         ticks_ff <= ticks_in;
      end
   end

endmodule

FILE: rtl/core/dapss_queue.sv
// Two-entry queue of classified ticks between front and back.
// Depends on dapss_pkg.
module dapss_queue
   import dapss_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  tick_type push_tick,
   output logic     push_ready,
   input  logic     pop_ready,
   output logic     pop_valid,
   output tick_type pop_tick
);

   tick_type   entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       pop_fire;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_tick   = entry_ff[rd_ptr_ff];
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (push_valid && !pop_fire) begin
         count_in = count_ff + 2'd1;
      end else if (pop_fire && !push_valid) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_tick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push_valid) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop_fire) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

endmodule

FILE: rtl/core/dapss_pid_loop.sv
// One PID loop: integral and previous-error state, then registered gain products.
// Depends on dapss_pkg.
module dapss_pid_loop
   import dapss_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load1,
   input  logic                    update,
   input  logic signed [ERR_W-1:0] err,
   input  logic                    load2,
   input  gains_type               gains,
   output logic signed [SUM_W-1:0] loop_sum
);

   logic signed [ACC_WIDTH-1:0] integral_ff;
   logic signed [ERR_W-1:0]     prev_ff;

   logic signed [ERR_W-1:0]     e1_ff;
   logic signed [ACC_WIDTH-1:0] acc1_ff;
   logic signed [RATE_W-1:0]    rate1_ff;

   logic signed [TERM_P_W-1:0]  term_p_ff;
   logic signed [TERM_I_W-1:0]  term_i_ff;
   logic signed [TERM_D_W-1:0]  term_d_ff;

   logic signed [ACC_WIDTH:0]   acc_wide;
   logic signed [ACC_WIDTH-1:0] acc_in;
   logic signed [RATE_W-1:0]    rate_in;
   logic signed [PROD_P_W-1:0]  prod_p;
   logic signed [PROD_I_W-1:0]  prod_i;
   logic signed [PROD_D_W-1:0]  prod_d;

   always_comb begin
      acc_wide = (ACC_WIDTH+1)'(integral_ff) + (ACC_WIDTH+1)'(err);
      // Clamp to the accumulator range when the top two bits disagree
      if (acc_wide[ACC_WIDTH] != acc_wide[ACC_WIDTH-1]) begin
         acc_in = {acc_wide[ACC_WIDTH], {(ACC_WIDTH-1){!acc_wide[ACC_WIDTH]}}};
      end else begin
         acc_in = acc_wide[ACC_WIDTH-1:0];
      end
      rate_in = RATE_W'(err) - RATE_W'(prev_ff);
   end

   assign prod_p = $signed({1'b0, gains.kp}) * e1_ff;
   assign prod_i = $signed({1'b0, gains.ki}) * acc1_ff;
   assign prod_d = $signed({1'b0, gains.kd}) * rate1_ff;

   assign loop_sum = SUM_W'(term_p_ff) + SUM_W'(term_i_ff) + SUM_W'(term_d_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff <= '0;
         prev_ff     <= '0;
      end else if (update) begin
         integral_ff <= acc_in;
         prev_ff     <= err;
      end
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         e1_ff    <= err;
         acc1_ff  <= acc_in;
         rate1_ff <= rate_in;
      end
      // Dropping the low bits of a signed product floors it
      if (load2) begin
         term_p_ff <= $signed(prod_p[PROD_P_W-1:FRAC_BITS]);
         term_i_ff <= $signed(prod_i[PROD_I_W-1:FRAC_BITS]);
         term_d_ff <= $signed(prod_d[PROD_D_W-1:FRAC_BITS]);
      end
   end

endmodule

FILE: rtl/core/dapss_back.sv
// Back end: three-stage pipeline over both PID loops, final sum, saturation and output register.
// Depends on dapss_pkg and dapss_pid_loop.
module dapss_back
   import dapss_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   input  tick_type                pop_tick,
   output logic                    pop_ready,
   input  gains_type               target_gains,
   input  gains_type               dock_gains,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [OUT_W-1:0] rsp_steer_command,
   output logic                    rsp_timed_out
);

   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic s1_timed_ff, s2_timed_ff, rsp_timed_ff;
   logic signed [OUT_W-1:0] steer_ff;
   logic signed [OUT_W-1:0] steer_in;

   logic adv1, adv2, adv3, pop_fire;
   logic signed [SUM_W-1:0] target_sum, dock_sum, total;

   assign adv3      = !rsp_valid_ff || rsp_ready;
   assign adv2      = !s2_valid_ff || adv3;
   assign adv1      = !s1_valid_ff || adv2;
   assign pop_ready = adv1;
   assign pop_fire  = pop_valid && adv1;

   dapss_pid_loop u_target_loop (
      .clock    (clock),
      .reset    (reset),
      .load1    (pop_fire),
      .update   (pop_fire && !pop_tick.timed_out),
      .err      (pop_tick.target_error),
      .load2    (adv2 && s1_valid_ff),
      .gains    (target_gains),
      .loop_sum (target_sum)
   );

   dapss_pid_loop u_dock_loop (
      .clock    (clock),
      .reset    (reset),
      .load1    (pop_fire),
      .update   (pop_fire && !pop_tick.timed_out),
      .err      (pop_tick.dock_error),
      .load2    (adv2 && s1_valid_ff),
      .gains    (dock_gains),
      .loop_sum (dock_sum)
   );

   always_comb begin
      total = target_sum + dock_sum;
      if (s2_timed_ff) begin
         steer_in = '0;
      end else if (total > SUM_W'(OUT_MAX)) begin
         steer_in = OUT_MAX;
      end else if (total < SUM_W'(OUT_MIN)) begin
         steer_in = OUT_MIN;
      end else begin
         steer_in = total[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_valid_ff <= pop_valid;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (adv3) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop_fire) begin
         s1_timed_ff <= pop_tick.timed_out;
      end
      if (adv2 && s1_valid_ff) begin
         s2_timed_ff <= s1_timed_ff;
      end
      // Hold the result until its transfer completes
      if (adv3 && s2_valid_ff) begin
         steer_ff     <= steer_in;
         rsp_timed_ff <= s2_timed_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_steer_command = steer_ff;
   assign rsp_timed_out     = rsp_timed_ff;

endmodule

FILE: bench/tb.sv
// Self-checking bench for dual_angle_pid_steering_unit: random and directed control ticks
// are scored against an in-bench model of both wrapped PID loops and the detection timeout.
// Depends on dapss_pkg and the RTL of the unit.
module tb
   import dapss_pkg::*;
();

   localparam int         QUIET_LIMIT = 2000;
   localparam int         LONG_STALL  = 200;
   localparam int         SETTLE      = 6;
   localparam int         TARGET_LOOP = 0;
   localparam int         DOCK_LOOP   = 1;
   localparam int         RAMP_TICKS  = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;
   localparam logic [GAIN_W-1:0]    GAIN_MAX  = 16'hFFFF;
   localparam longint     ACC_HI = (longint'(1) <<< (ACC_WIDTH - 1)) - 1;
   localparam longint     ACC_LO = -ACC_HI - 1;
   localparam logic signed [ERR_W-1:0] PI_E = ERR_W'(PI_L);

   typedef struct packed {
      logic signed [ERR_W-1:0] target_error;
      logic signed [ERR_W-1:0] dock_error;
      logic                    target_seen;
   } bearing_tick_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] steer_command;
      logic                    timed_out;
   } steer_out_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [GAIN_W-1:0]       csr_data = '0;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic signed [ERR_W-1:0] req_target_error = '0;
   logic signed [ERR_W-1:0] req_dock_error = '0;
   logic                    req_target_seen = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [OUT_W-1:0] rsp_steer_command;
   logic                    rsp_timed_out;

   dual_angle_pid_steering_unit u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Model state
   gains_type     model_gains [2];
   logic [TICK_W-1:0] model_timeout;
   logic [TICK_W-1:0] model_ticks;
   longint        loop_integral [2];
   longint        loop_prev [2];

   bearing_tick_type tick_backlog [$];
   steer_out_type    steer_due [$];
   bearing_tick_type cur_tick;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   logic          long_stall_go = 1'b0;
   int            hold_left = 0;
   int            quiet_cycles = 0;
   int            fail_count = 0;

   function automatic void reset_model();
      for (int k = 0; k < 2; k++) begin
         model_gains[k] = '{KP_RESET, KI_RESET, KD_RESET};
         loop_integral[k] = 0;
         loop_prev[k] = 0;
      end
      model_timeout = TIMEOUT_RESET;
      model_ticks = TICKS_SAT;
   endfunction

   function automatic longint pid_loop(int which, logic signed [ERR_W-1:0] err);
      longint e, acc, rate, kp, ki, kd;
      e = err;
      kp = model_gains[which].kp;
      ki = model_gains[which].ki;
      kd = model_gains[which].kd;
      if (e > PI_L) e = e - 2 * PI_L;
      if (e < -PI_L) e = e + 2 * PI_L;
      acc = loop_integral[which] + e;
      if (acc > ACC_HI) acc = ACC_HI;
      if (acc < ACC_LO) acc = ACC_LO;
      loop_integral[which] = acc;
      rate = e - loop_prev[which];
      loop_prev[which] = e;
      return ((kp * e) >>> FRAC_BITS) + ((ki * acc) >>> FRAC_BITS)
         + ((kd * rate) >>> FRAC_BITS);
   endfunction

   function automatic steer_out_type compute_steer(bearing_tick_type t);
      steer_out_type r;
      longint sum;
      if (t.target_seen) model_ticks = '0;
      else if (model_ticks != TICKS_SAT) model_ticks = model_ticks + 1'b1;
      if (model_ticks > model_timeout) begin
         r.steer_command = '0;
         r.timed_out = 1'b1;
         return r;
      end
      sum = pid_loop(TARGET_LOOP, t.target_error);
      sum = sum + pid_loop(DOCK_LOOP, t.dock_error);
      if (sum > OUT_MAX) sum = OUT_MAX;
      if (sum < OUT_MIN) sum = OUT_MIN;
      r.steer_command = sum[OUT_W-1:0];
      r.timed_out = 1'b0;
      return r;
   endfunction

   // Sender: present the next tick once the current one has transferred
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) steer_due.push_back(compute_steer(cur_tick));
         if (!req_valid || req_ready) begin
            if (tick_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_tick = tick_backlog.pop_front();
               req_target_error <= cur_tick.target_error;
               req_dock_error <= cur_tick.dock_error;
               req_target_seen <= cur_tick.target_seen;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (long_stall_go) begin
         long_stall_go <= 1'b0;
         hold_left <= LONG_STALL;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : check_steer
      steer_out_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (steer_due.size() == 0) begin
            $error("unexpected result: steer_command %0d timed_out %0b",
               rsp_steer_command, rsp_timed_out);
            fail_count = fail_count + 1;
         end else begin
            want = steer_due.pop_front();
            if (rsp_steer_command !== want.steer_command) begin
               $error("steer_command: expected %0d, got %0d",
                  $signed(want.steer_command), rsp_steer_command);
               fail_count = fail_count + 1;
            end
            if (rsp_timed_out !== want.timed_out) begin
               $error("timed_out: expected %0b, got %0b", want.timed_out, rsp_timed_out);
               fail_count = fail_count + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("dual_angle_pid_steering_unit: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Call at a rising edge; leaves csr_valid high for a following write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_TARGET_KP: model_gains[TARGET_LOOP].kp = val;
         CSR_TARGET_KI: model_gains[TARGET_LOOP].ki = val;
         CSR_TARGET_KD: model_gains[TARGET_LOOP].kd = val;
         CSR_DOCK_KP:   model_gains[DOCK_LOOP].kp = val;
         CSR_DOCK_KI:   model_gains[DOCK_LOOP].ki = val;
         CSR_DOCK_KD:   model_gains[DOCK_LOOP].kd = val;
         CSR_TIMEOUT:   model_timeout = val;
         default: ;
      endcase
   endtask

   task automatic program_all(input gains_type tg, input gains_type dg,
                              input logic [TICK_W-1:0] tmo);
      @(posedge clock);
      write_reg(CSR_TARGET_KP, tg.kp);
      write_reg(CSR_TARGET_KI, tg.ki);
      write_reg(CSR_TARGET_KD, tg.kd);
      write_reg(CSR_DOCK_KP, dg.kp);
      write_reg(CSR_DOCK_KI, dg.ki);
      write_reg(CSR_DOCK_KD, dg.kd);
      write_reg(CSR_TIMEOUT, tmo);
      write_reg(CSR_SPARE, GAIN_W'($urandom));
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Hold until the unit is empty and every result has been scored
   task automatic drain();
      while (tick_backlog.size() != 0 || req_valid || steer_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic queue_tick(input logic signed [ERR_W-1:0] te,
                             input logic signed [ERR_W-1:0] de, input logic seen);
      bearing_tick_type t;
      t.target_error = te;
      t.dock_error = de;
      t.target_seen = seen;
      tick_backlog.push_back(t);
   endtask

   function automatic logic signed [ERR_W-1:0] pick_error();
      case ($urandom_range(7))
         0, 1, 2: return ERR_W'($urandom);
         3: return PI_E - 16'sd2 + ERR_W'($urandom_range(4));
         4: return -PI_E - 16'sd2 + ERR_W'($urandom_range(4));
         5: begin
            case ($urandom_range(3))
               0: return 16'sh7FFF;
               1: return 16'sh8000;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return ERR_W'($urandom_range(1024)) - 16'sd512;
      endcase
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(7))
         0: return '0;
         1: return GAIN_MAX;
         default: return GAIN_W'($urandom);
      endcase
   endfunction

   function automatic logic [TICK_W-1:0] pick_timeout();
      case ($urandom_range(6))
         0: return '0;
         1: return TICKS_SAT;
         2: return TICKS_SAT - 1'b1;
         3: return TICK_W'($urandom_range(8, 1));
         4: return TIMEOUT_RESET;
         default: return TICK_W'($urandom_range(40, 2));
      endcase
   endfunction

   task automatic random_ticks(input int n, input int seen_pct);
      for (int i = 0; i < n; i++)
         queue_tick(pick_error(), pick_error(), $urandom_range(99) < seen_pct);
   endtask

   initial begin : stimulus
      gains_type tg, dg;
      int seen_pct;
      reset_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default settings; the detection timer starts saturated
      queue_tick(16'sd0, 16'sd0, 1'b0);
      queue_tick(16'sh7FFF, 16'sh8000, 1'b1);
      queue_tick(16'sh8000, 16'sh7FFF, 1'b0);
      queue_tick(PI_E, -PI_E, 1'b1);
      queue_tick(PI_E + 1'b1, -PI_E - 1'b1, 1'b1);
      queue_tick(-16'sd1, 16'sd1, 1'b1);
      drain();

      // Short timeout: three quiet ticks pass, the fourth times out
      program_all('{GAIN_MAX, '0, GAIN_MAX}, '{'0, GAIN_MAX, '0}, 16'd3);
      queue_tick(16'sd1000, -16'sd1000, 1'b1);
      repeat (3) queue_tick(16'sd300, 16'sd200, 1'b0);
      queue_tick(16'sd300, 16'sd200, 1'b0);
      queue_tick(-16'sd300, 16'sd200, 1'b0);
      queue_tick(16'sd50, -16'sd70, 1'b1);
      drain();

      // Zero timeout: only ticks with a detection run the loops
      program_all('{KP_RESET, KI_RESET, KD_RESET}, '{KP_RESET, KI_RESET, KD_RESET}, '0);
      queue_tick(16'sd4000, 16'sd4000, 1'b1);
      queue_tick(16'sd4000, 16'sd4000, 1'b0);
      queue_tick(-16'sd4000, -16'sd4000, 1'b1);
      drain();

      for (int mode = 0; mode < 4; mode++) begin
         case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
            default: begin send_idle_pct = 38; recv_stall_pct = 38; end
         endcase
         for (int sub = 0; sub < 3; sub++) begin
            tg = '{pick_gain(), pick_gain(), pick_gain()};
            dg = '{pick_gain(), pick_gain(), pick_gain()};
            program_all(tg, dg, pick_timeout());
            case ($urandom_range(2))
               0: seen_pct = 95;
               1: seen_pct = 70;
               default: seen_pct = 30;
            endcase
            // Back up the unit while the sender keeps offering
            if (mode == 0 && sub == 0) long_stall_go <= 1'b1;
            if (mode == 2 && sub == 1) begin
               random_ticks(25, seen_pct);
               drain();
               random_ticks(25, seen_pct);
            end else begin
               random_ticks(50, seen_pct);
            end
            drain();
         end
      end

      // Ramp both integrators with tiny gains; the largest timeout never fires
      send_idle_pct = 0;
      recv_stall_pct = 0;
      program_all('{16'd1, 16'd1, 16'd1}, '{16'd1, 16'd1, 16'd1}, TICKS_SAT);
      queue_tick(PI_E, -PI_E, 1'b1);
      for (int i = 1; i < RAMP_TICKS; i++) queue_tick(PI_E, -PI_E, 1'b0);
      drain();
      program_all('{'0, GAIN_MAX, '0}, '{'0, '0, '0}, TICKS_SAT);
      repeat (4) queue_tick(PI_E, -PI_E, 1'b0);
      drain();
      program_all('{'0, '0, '0}, '{'0, GAIN_MAX, '0}, TICKS_SAT);
      repeat (4) queue_tick(PI_E, -PI_E, 1'b0);
      drain();

      // Largest finite timeout with the integral terms off
      send_idle_pct = 38;
      recv_stall_pct = 38;
      tg = '{pick_gain(), '0, pick_gain()};
      dg = '{pick_gain(), '0, pick_gain()};
      program_all(tg, dg, TICKS_SAT - 1'b1);
      repeat (4) queue_tick(pick_error(), pick_error(), 1'b0);
      queue_tick(pick_error(), pick_error(), 1'b1);
      random_ticks(20, 50);
      drain();

      if (fail_count == 0) begin
         $display("dual_angle_pid_steering_unit: match");
      end else begin
         $display("dual_angle_pid_steering_unit: mismatch");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/dapss_pkg.sv
rtl/core/dapss_front.sv
rtl/core/dapss_queue.sv
rtl/core/dapss_pid_loop.sv
rtl/core/dapss_back.sv
rtl/core/dual_angle_pid_steering_unit.sv
bench/tb.sv
